FILE: rtl/pmtu_pkg.sv
package pmtu_pkg;

    // Field widths
    localparam int SizeW = 14;
    localparam int CountW = 8;
    localparam int CmdW = 3;
    localparam int ValW = 16;
    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 14;
    localparam int OutDataW = 64;

    // Register reset values
    localparam logic [SizeW-1:0] MinSizeRst = 14'd1200;
    localparam logic [SizeW-1:0] MaxSizeRst = 14'd1500;
    localparam logic [SizeW-1:0] StepRst = 14'd10;
    localparam logic [SizeW-1:0] TargetRst = 14'd1500;
    localparam logic [CountW-1:0] BlackholeRst = 8'd3;
    localparam logic [SizeW-1:0] MtuRst = 14'd1200;
    localparam logic [CountW-1:0] FailSat = 8'hFF;

    // Configuration register indexes
    typedef enum logic [CfgAddrW-1:0] {
        REG_MIN_SIZE = 3'd0,
        REG_MAX_SIZE = 3'd1,
        REG_STEP = 3'd2,
        REG_TARGET = 3'd3,
        REG_BLACKHOLE = 3'd4
    } cfg_reg_t;

    // Command codes
    typedef enum logic [CmdW-1:0] {
        CMD_ENABLE = 3'd0,
        CMD_DISABLE = 3'd1,
        CMD_SET = 3'd2,
        CMD_UPDATE = 3'd3,
        CMD_PROBE_OK = 3'd4,
        CMD_PROBE_FAIL = 3'd5,
        CMD_RESTART = 3'd6
    } cmd_t;

    // Result item, first field in the highest bits
    typedef struct packed {
        logic             enabled;
        logic [SizeW-1:0] path_mtu;
        logic             validated;
        logic             searching;
        logic [SizeW-1:0] link_limit;
        logic [SizeW-1:0] current_size;
        logic [SizeW-1:0] probe_len;
        logic             probe_send;
        logic             accepted;
    } result_t;

    localparam int ResultW = $bits(result_t);

endpackage

FILE: rtl/path_mtu_probe_search.sv
// A command transferred at one clock edge has its result on m_tdata right after that edge.
// Throughput: one command per cycle; s_tready stays high while the result register is empty
// or being drained in the same cycle.
// Reset (rst_n low, asynchronous): configuration returns to its defaults, discovery is off,
// all search sizes read 1200, the failure count is zero and no result is pending.
module path_mtu_probe_search (
    input  logic                              clk,
    input  logic                              rst_n,
    // Command stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pmtu_pkg::ValW-1:0]         s_tdata,   // [15:0] mtu_value
    input  logic [pmtu_pkg::CmdW-1:0]         s_tuser,   // [2:0] cmd
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] accepted, [1] probe_send, [15:2] probe_len, [29:16] current_size,
    // [43:30] link_limit, [44] searching, [45] validated, [59:46] path_mtu,
    // [60] enabled, [63:61] zero
    output logic [pmtu_pkg::OutDataW-1:0]     m_tdata,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [pmtu_pkg::CfgAddrW-1:0]     cfg_addr,
    input  logic [pmtu_pkg::CfgDataW-1:0]     cfg_wdata
);
    import pmtu_pkg::*;

    // Configuration registers
    logic [SizeW-1:0]  min_size_reg;
    logic [SizeW-1:0]  max_size_reg;
    logic [SizeW-1:0]  step_reg;
    logic [SizeW-1:0]  target_reg;
    logic [CountW-1:0] blackhole_reg;

    // Search state
    logic              enable_reg, enable_next;
    logic              search_reg, search_next;
    logic              valid_reg, valid_next;
    logic [SizeW-1:0]  cur_reg, cur_next;
    logic [SizeW-1:0]  good_reg, good_next;
    logic [SizeW-1:0]  trial_reg, trial_next;
    logic [SizeW-1:0]  found_reg, found_next;
    logic [SizeW-1:0]  limit_reg, limit_next;
    logic [CountW-1:0] fail_reg, fail_next;

    // Result register
    result_t           res_reg, res_next;
    logic              out_valid_reg;

    logic              s_fire;
    cmd_t              cmd;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire = s_tvalid && s_tready;
    assign cmd = cmd_t'(s_tuser);
    assign m_tvalid = out_valid_reg;
    assign m_tdata = {{(OutDataW - ResultW){1'b0}}, res_reg};

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_size_reg <= MinSizeRst;
            max_size_reg <= MaxSizeRst;
            step_reg <= StepRst;
            target_reg <= TargetRst;
            blackhole_reg <= BlackholeRst;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MIN_SIZE: min_size_reg <= cfg_wdata;
                REG_MAX_SIZE: max_size_reg <= cfg_wdata;
                REG_STEP: step_reg <= cfg_wdata;
                REG_TARGET: target_reg <= cfg_wdata;
                REG_BLACKHOLE: blackhole_reg <= cfg_wdata[CountW-1:0];
                default: ;
            endcase
        end
    end

    // Command decode and next state
    always_comb
    begin
        logic [SizeW:0]    start_sum;
        logic [SizeW-1:0]  start_trial;
        logic [SizeW:0]    up_sum;
        logic [SizeW-1:0]  up_trial;
        logic [CountW-1:0] fail_inc;
        logic [SizeW-1:0]  gap;
        logic [SizeW:0]    mid_sum;
        logic              val_ok;
        logic              accepted;
        logic              send;

        enable_next = enable_reg;
        search_next = search_reg;
        valid_next = valid_reg;
        cur_next = cur_reg;
        good_next = good_reg;
        trial_next = trial_reg;
        found_next = found_reg;
        limit_next = limit_reg;
        fail_next = fail_reg;
        accepted = 1'b1;
        send = 1'b0;

        // first probe of a new search starts one step above the minimum, capped at the maximum
        start_sum = {1'b0, min_size_reg} + {1'b0, step_reg};
        start_trial = (start_sum < {1'b0, max_size_reg}) ? start_sum[SizeW-1:0]
                                                          : max_size_reg;
        // next upward probe
        up_sum = {1'b0, trial_reg} + {1'b0, step_reg};
        up_trial = (up_sum < {1'b0, max_size_reg}) ? up_sum[SizeW-1:0] : max_size_reg;
        // failure bookkeeping and bisection point
        fail_inc = (fail_reg != FailSat) ? fail_reg + 1'b1 : fail_reg;
        gap = (trial_reg > good_reg) ? trial_reg - good_reg : '0;
        mid_sum = {1'b0, good_reg} + {2'b00, gap[SizeW-1:1]};
        val_ok = (s_tdata >= {{(ValW - SizeW){1'b0}}, min_size_reg})
              && (s_tdata <= {{(ValW - SizeW){1'b0}}, max_size_reg});

        case (cmd)
            CMD_ENABLE:
            begin
                if (!enable_reg)
                begin
                    enable_next = 1'b1;
                    cur_next = min_size_reg;
                    good_next = min_size_reg;
                    valid_next = 1'b0;
                    found_next = min_size_reg;
                    limit_next = min_size_reg;
                    search_next = 1'b1;
                    fail_next = '0;
                    trial_next = start_trial;
                    send = 1'b1;
                end
            end
            CMD_DISABLE:
            begin
                if (enable_reg)
                begin
                    enable_next = 1'b0;
                    limit_next = good_reg;
                end
            end
            CMD_SET, CMD_UPDATE:
            begin
                if (!val_ok)
                begin
                    accepted = 1'b0;
                end
                else
                begin
                    cur_next = s_tdata[SizeW-1:0];
                    limit_next = s_tdata[SizeW-1:0];
                    if (cmd == CMD_SET)
                    begin
                        good_next = s_tdata[SizeW-1:0];
                    end
                end
            end
            CMD_PROBE_OK:
            begin
                if (enable_reg && search_reg)
                begin
                    good_next = trial_reg;
                    fail_next = '0;
                    if (trial_reg >= target_reg || trial_reg >= max_size_reg)
                    begin
                        valid_next = 1'b1;
                        found_next = trial_reg;
                        cur_next = trial_reg;
                        limit_next = trial_reg;
                        search_next = 1'b0;
                    end
                    else
                    begin
                        trial_next = up_trial;
                        send = 1'b1;
                    end
                end
            end
            CMD_PROBE_FAIL:
            begin
                if (enable_reg && search_reg)
                begin
                    fail_next = fail_inc;
                    if (fail_inc >= blackhole_reg || gap <= step_reg)
                    begin
                        // blackhole or gap closed: settle on the last good size
                        if (fail_inc < blackhole_reg)
                        begin
                            trial_next = good_reg;
                        end
                        valid_next = 1'b1;
                        found_next = good_reg;
                        cur_next = good_reg;
                        limit_next = good_reg;
                        search_next = 1'b0;
                    end
                    else
                    begin
                        trial_next = mid_sum[SizeW-1:0];
                        send = 1'b1;
                    end
                end
            end
            CMD_RESTART:
            begin
                search_next = enable_reg;
                valid_next = 1'b0;
                fail_next = '0;
                cur_next = min_size_reg;
                good_next = min_size_reg;
                found_next = min_size_reg;
                limit_next = min_size_reg;
                if (enable_reg)
                begin
                    trial_next = start_trial;
                    send = 1'b1;
                end
            end
            default: ;
        endcase

        res_next.accepted = accepted;
        res_next.probe_send = send;
        res_next.probe_len = trial_next;
        res_next.current_size = cur_next;
        res_next.link_limit = limit_next;
        res_next.searching = search_next;
        res_next.validated = valid_next;
        res_next.path_mtu = found_next;
        res_next.enabled = enable_next;
    end

    // State update on each command transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            search_reg <= 1'b0;
            valid_reg <= 1'b0;
            cur_reg <= MtuRst;
            good_reg <= MtuRst;
            trial_reg <= MtuRst;
            found_reg <= MtuRst;
            limit_reg <= MtuRst;
            fail_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                enable_reg <= enable_next;
                search_reg <= search_next;
                valid_reg <= valid_next;
                cur_reg <= cur_next;
                good_reg <= good_next;
                trial_reg <= trial_next;
                found_reg <= found_next;
                limit_reg <= limit_next;
                fail_reg <= fail_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            res_reg <= res_next;
        end
    end

    // A probe is only requested while enabled and searching
    a_probe_needs_search: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.probe_send |-> res_reg.searching && res_reg.enabled)
        else $error("probe requested outside an active search");

    // Disable always reports discovery off
    a_disable_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && s_tuser == CMD_DISABLE |=> !res_reg.enabled && !enable_reg)
        else $error("disable left discovery enabled");

    // Restart puts the current size back at the minimum
    a_restart_min: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && s_tuser == CMD_RESTART && !cfg_we
        |=> cur_reg == $past(min_size_reg) && !valid_reg)
        else $error("restart did not return to the minimum size");

endmodule
